/* hw/rtl/ple_pkg.sv */
// ple_pkg: request modes, status codes and cell control types shared by the
// positional list engine files. No dependencies.
package ple_pkg;

  // positions and counts for any depth up to 127 entries
  localparam int POS_W = 7;

  localparam logic [2:0] MODE_INS_FRONT = 3'd0;
  localparam logic [2:0] MODE_INS_BACK  = 3'd1;
  localparam logic [2:0] MODE_INS_AT    = 3'd2;
  localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
  localparam logic [2:0] MODE_DEL_BACK  = 3'd4;
  localparam logic [2:0] MODE_DEL_AT    = 3'd5;
  localparam logic [2:0] MODE_SEARCH    = 3'd6;
  localparam logic [2:0] MODE_READ_ALL  = 3'd7;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_BAD_INDEX = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] CELL_HOLD   = 2'd0;
  localparam logic [1:0] CELL_INSERT = 2'd1;
  localparam logic [1:0] CELL_DELETE = 2'd2;
  localparam logic [1:0] CELL_ROTATE = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] tail;
  } cell_ctrl_t;

endpackage

/* hw/rtl/ple_if.sv */
// ple_if: valid/ready channels for list requests and list results.
// Depends on nothing; payload fields follow the engine's word formats.
interface ple_req_if;
  logic              valid;
  logic              ready;
  logic [2:0]        mode;
  logic signed [31:0] value;
  logic [4:0]        position;

  modport source (output valid, mode, value, position, input ready);
  modport sink   (input valid, mode, value, position, output ready);
endinterface

interface ple_rsp_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [3:0]         found_index;
  logic signed [31:0] element;
  logic [3:0]         element_index;
  logic               last;
  logic [4:0]         count;
  logic signed [31:0] min_value;
  logic signed [31:0] max_value;

  modport source (output valid, status, found_index, element, element_index, last, count,
                  min_value, max_value, input ready);
  modport sink   (input valid, status, found_index, element, element_index, last, count,
                  min_value, max_value, output ready);
endinterface

/* hw/rtl/ple_cell.sv */
// ple_cell: one list position; shifts toward or away from its neighbors on
// insert, delete and rotate. Depends on ple_pkg.
module ple_cell #(
  parameter int INDEX       = 0,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  ple_pkg::cell_ctrl_t    ctrl,
  input  logic [VALUE_WIDTH-1:0] left,
  input  logic [VALUE_WIDTH-1:0] right,
  input  logic [VALUE_WIDTH-1:0] head,
  input  logic [VALUE_WIDTH-1:0] new_value,
  output logic [VALUE_WIDTH-1:0] q
);
  import ple_pkg::*;

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  logic [VALUE_WIDTH-1:0] q_next;

  always_comb begin
    q_next = q;
    unique case (ctrl.op)
      CELL_HOLD: q_next = q;
      CELL_INSERT: begin
        if (IDX > ctrl.pos) q_next = left;
        else if (IDX == ctrl.pos) q_next = new_value;
      end
      CELL_DELETE: begin
        if (IDX >= ctrl.pos) q_next = right;
      end
      CELL_ROTATE: begin
        if (IDX == ctrl.tail) q_next = head;
        else q_next = right;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

/* hw/rtl/positional_list_engine.sv */
// positional_list_engine: ordered list of signed values held in a row of cells
// that rotates as a circular list. Depends on ple_pkg, ple_if and ple_cell.
//
// Usage: requests arrive on req (mode, value, position) and results leave on
// rsp. A request is taken only while the engine is idle; inserts and deletes
// shift the cell row in the accepting cycle. The row then rotates once around
// its count live entries, one entry per cycle past cell 0, to gather the
// minimum, maximum and first search match, count being the number of entries
// after the request. Except for a successful read all, the result word then
// enters the output register once that register is free. Read all makes a
// second rotation pass that emits one word per entry, at one word per cycle,
// with last on the final word. A stalled receiver freezes the rotation; the
// output register lets the next request be taken while the last word still
// waits. Refused requests leave the list as it was. Reset empties the list at
// once; the cell contents need no clearing.
module positional_list_engine #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  ple_req_if.sink   req,
  ple_rsp_if.source rsp
);
  import ple_pkg::*;

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int EXT_W = (VALUE_WIDTH > 32) ? VALUE_WIDTH : 32;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;
  localparam logic [1:0] S_READ   = 2'd3;

  function automatic logic [31:0] to_field(input logic [VALUE_WIDTH-1:0] v);
    logic signed [EXT_W-1:0] e;
    e = EXT_W'(signed'(v));
    return e[31:0];
  endfunction

  logic [1:0]             state;
  logic [CW-1:0]          count;
  logic [CW-1:0]          k;
  logic [2:0]             mode_r;
  logic [VALUE_WIDTH-1:0] key;
  logic [2:0]             status_r;
  logic                   found;
  logic [CW-1:0]          fidx;
  logic [VALUE_WIDTH-1:0] lo;
  logic [VALUE_WIDTH-1:0] hi;

  logic                   out_valid;
  logic [2:0]             out_status;
  logic [3:0]             out_fidx;
  logic [31:0]            out_elem;
  logic [3:0]             out_eidx;
  logic                   out_last;
  logic [4:0]             out_count;
  logic [31:0]            out_min;
  logic [31:0]            out_max;

  logic [VALUE_WIDTH-1:0] cell_q [DEPTH];
  logic [VALUE_WIDTH-1:0] head;
  logic [VALUE_WIDTH-1:0] new_value;
  cell_ctrl_t             ctrl;

  logic                   accept;
  logic                   out_free;
  logic                   load_out;
  logic                   do_ins;
  logic                   do_del;
  logic [POS_W-1:0]       tpos;
  logic [2:0]             st;
  logic [POS_W-1:0]       pos_x;
  logic [POS_W-1:0]       cnt_x;
  logic [CW-1:0]          count_after;
  logic [CW-1:0]          tail_idx;

  assign head      = cell_q[0];
  assign new_value = VALUE_WIDTH'(req.value);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign pos_x     = POS_W'(req.position);
  assign cnt_x     = POS_W'(count);
  assign tail_idx  = count - CW'(1);
  assign req.ready = !rst && (state == S_IDLE);

  // output register loads a word in these cycles
  assign load_out = out_free &&
                    ((state == S_RESULT && !(mode_r == MODE_READ_ALL && status_r == ST_OK)) ||
                     state == S_READ);

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    tpos   = '0;
    st     = ST_OK;
    case (req.mode) inside
      MODE_INS_FRONT, MODE_INS_BACK, MODE_INS_AT: begin
        if (req.mode == MODE_INS_BACK) tpos = cnt_x;
        else if (req.mode == MODE_INS_AT) tpos = pos_x;
        if (count == CW'(DEPTH)) st = ST_FULL;
        else if (tpos > cnt_x) st = ST_BAD_INDEX;
        else do_ins = 1'b1;
      end
      MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
        if (req.mode == MODE_DEL_BACK) tpos = cnt_x - POS_W'(1);
        else if (req.mode == MODE_DEL_AT) tpos = pos_x;
        if (count == '0) st = ST_EMPTY;
        else if (tpos >= cnt_x) st = ST_BAD_INDEX;
        else do_del = 1'b1;
      end
      default: begin
        if (count == '0) st = ST_EMPTY;
      end
    endcase
  end

  always_comb begin
    if (do_ins) count_after = count + CW'(1);
    else if (do_del) count_after = count - CW'(1);
    else count_after = count;
  end

  always_comb begin
    ctrl.op   = CELL_HOLD;
    ctrl.pos  = tpos;
    ctrl.tail = POS_W'(tail_idx);
    unique case (state)
      S_IDLE: begin
        if (accept && do_ins) ctrl.op = CELL_INSERT;
        else if (accept && do_del) ctrl.op = CELL_DELETE;
      end
      S_SCAN: ctrl.op = CELL_ROTATE;
      S_READ: begin
        if (out_free) ctrl.op = CELL_ROTATE;
      end
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    ple_cell #(
      .INDEX       (i),
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left      (cell_q[(i == 0) ? 0 : i - 1]),
      .right     (cell_q[(i == DEPTH - 1) ? i : i + 1]),
      .head      (head),
      .new_value (new_value),
      .q         (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      k         <= '0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && rsp.ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            mode_r   <= req.mode;
            key      <= new_value;
            status_r <= st;
            count    <= count_after;
            k        <= '0;
            found    <= 1'b0;
            fidx     <= '0;
            state    <= (count_after == '0) ? S_RESULT : S_SCAN;
          end
        end
        S_SCAN: begin
          if (k == '0) begin
            lo <= head;
            hi <= head;
          end else begin
            if ($signed(head) < $signed(lo)) lo <= head;
            if ($signed(head) > $signed(hi)) hi <= head;
          end
          if (mode_r == MODE_SEARCH && !found && head == key) begin
            found <= 1'b1;
            fidx  <= k;
          end
          if (k == tail_idx) begin
            k     <= '0;
            state <= S_RESULT;
          end else begin
            k <= k + CW'(1);
          end
        end
        S_RESULT: begin
          if (mode_r == MODE_READ_ALL && status_r == ST_OK) begin
            state <= S_READ;
          end else if (out_free) begin
            out_status <= (mode_r == MODE_SEARCH && status_r == ST_OK) ?
                          (found ? ST_OK : ST_NOT_FOUND) : status_r;
            out_fidx  <= found ? 4'(fidx) : 4'd0;
            out_elem  <= '0;
            out_eidx  <= '0;
            out_last  <= 1'b1;
            out_count <= 5'(count);
            out_min   <= (count == '0) ? 32'd0 : to_field(lo);
            out_max   <= (count == '0) ? 32'd0 : to_field(hi);
            state     <= S_IDLE;
          end
        end
        S_READ: begin
          if (out_free) begin
            out_status <= ST_OK;
            out_fidx   <= '0;
            out_elem   <= to_field(head);
            out_eidx   <= 4'(k);
            out_last   <= (k == tail_idx);
            out_count  <= 5'(count);
            out_min    <= to_field(lo);
            out_max    <= to_field(hi);
            if (k == tail_idx) begin
              k     <= '0;
              state <= S_IDLE;
            end else begin
              k <= k + CW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp.valid         = out_valid;
  assign rsp.status        = out_status;
  assign rsp.found_index   = out_fidx;
  assign rsp.element       = out_elem;
  assign rsp.element_index = out_eidx;
  assign rsp.last          = out_last;
  assign rsp.count         = out_count;
  assign rsp.min_value     = out_min;
  assign rsp.max_value     = out_max;

endmodule

/* dv/positional_list_engine_tb.sv */
// positional_list_engine_tb: self-checking bench for the positional list engine.
// Drives list requests in bursts, predicts every result word from a shadow list,
// and checks them in order. Depends on ple_pkg, ple_if and the engine RTL.
`timescale 1ns / 1ps

module positional_list_engine_tb;
  import ple_pkg::*;

  localparam int LIST_DEPTH   = 16;
  localparam int HOLD_CYCLES  = 250;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [2:0]         status;
    logic [3:0]         found_index;
    logic signed [31:0] element;
    logic [3:0]         element_index;
    logic               last;
    logic [4:0]         count;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
  } list_rsp_t;

  logic clk;
  logic rst;

  ple_req_if req_ch ();
  ple_rsp_if rsp_ch ();

  positional_list_engine #(
    .DEPTH(LIST_DEPTH),
    .VALUE_WIDTH(32)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  logic signed [31:0] shadow_list [LIST_DEPTH];
  int                 shadow_count;
  list_rsp_t          expected_q [$];
  list_rsp_t          want;

  int  error_count;
  int  sent_count;
  int  word_count;
  int  burst_left;
  int  idle_cycles;
  bit  hold_off;
  int  hold_left;
  int  rx_style;
  int  rx_left;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_INS_FRONT;
    req_ch.value    = '0;
    req_ch.position = '0;
    rsp_ch.ready    = 1'b0;
  end

  always #10 clk = ~clk;

  // shadow list
  function automatic void expect_word(logic [2:0] st, logic [3:0] fidx,
                                      logic signed [31:0] elem, logic [3:0] eidx,
                                      logic last_flag);
    list_rsp_t w;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
    lo = '0;
    hi = '0;
    if (shadow_count > 0) begin
      lo = shadow_list[0];
      hi = shadow_list[0];
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_list[i] < lo) lo = shadow_list[i];
        if (shadow_list[i] > hi) hi = shadow_list[i];
      end
    end
    w.status        = st;
    w.found_index   = fidx;
    w.element       = elem;
    w.element_index = eidx;
    w.last          = last_flag;
    w.count         = 5'(shadow_count);
    w.min_value     = lo;
    w.max_value     = hi;
    expected_q.push_back(w);
  endfunction

  function automatic logic [2:0] list_insert(int pos, logic signed [31:0] v);
    if (shadow_count >= LIST_DEPTH) return ST_FULL;
    if (pos > shadow_count) return ST_BAD_INDEX;
    for (int i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[pos] = v;
    shadow_count++;
    return ST_OK;
  endfunction

  function automatic logic [2:0] list_delete(int pos);
    if (shadow_count == 0) return ST_EMPTY;
    if (pos >= shadow_count) return ST_BAD_INDEX;
    for (int i = pos; i + 1 < shadow_count; i++) shadow_list[i] = shadow_list[i + 1];
    shadow_count--;
    return ST_OK;
  endfunction

  function automatic void apply_request(logic [2:0] m, logic signed [31:0] v, logic [4:0] p);
    logic [2:0] st;
    int hit;
    hit = -1;
    case (m)
      MODE_INS_FRONT: st = list_insert(0, v);
      MODE_INS_BACK:  st = list_insert(shadow_count, v);
      MODE_INS_AT:    st = list_insert(int'(p), v);
      MODE_DEL_FRONT: st = list_delete(0);
      MODE_DEL_BACK:  st = (shadow_count == 0) ? ST_EMPTY : list_delete(shadow_count - 1);
      MODE_DEL_AT:    st = list_delete(int'(p));
      MODE_SEARCH: begin
        for (int i = shadow_count - 1; i >= 0; i--) begin
          if (shadow_list[i] == v) hit = i;
        end
        if (shadow_count == 0) expect_word(ST_EMPTY, '0, '0, '0, 1'b1);
        else if (hit < 0) expect_word(ST_NOT_FOUND, '0, '0, '0, 1'b1);
        else expect_word(ST_OK, 4'(hit), '0, '0, 1'b1);
        return;
      end
      MODE_READ_ALL: begin
        if (shadow_count == 0) expect_word(ST_EMPTY, '0, '0, '0, 1'b1);
        for (int i = 0; i < shadow_count; i++) begin
          expect_word(ST_OK, '0, shadow_list[i], 4'(i), (i + 1 == shadow_count));
        end
        return;
      end
      default: st = ST_OK;
    endcase
    expect_word(st, '0, '0, '0, 1'b1);
  endfunction

  // request driver
  task automatic send_request(input logic [2:0] m, input logic signed [31:0] v,
                              input logic [4:0] p);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.mode     <= m;
    req_ch.value    <= v;
    req_ch.position <= p;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    apply_request(m, v, p);
    sent_count++;
  endtask

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2, 3, 4: return 32'(signed'($urandom_range(0, 16)) - 8);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(input int ins_weight);
    int r;
    logic [2:0] m;
    logic signed [31:0] v;
    logic [4:0] p;
    r = $urandom_range(0, 99);
    v = rand_value();
    if (r < ins_weight) m = 3'($urandom_range(0, 2));
    else if (r < 88) m = 3'($urandom_range(3, 5));
    else if (r < 95) m = MODE_SEARCH;
    else m = MODE_READ_ALL;
    if ($urandom_range(0, 4) == 0) p = 5'($urandom_range(0, 31));
    else if (m == MODE_INS_AT || shadow_count == 0) p = 5'($urandom_range(0, shadow_count));
    else p = 5'($urandom_range(0, shadow_count - 1));
    if (m == MODE_SEARCH && shadow_count > 0 && $urandom_range(0, 1) == 1) begin
      v = shadow_list[$urandom_range(0, shadow_count - 1)];
    end
    send_request(m, v, p);
  endtask

  // result checker
  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] got);
    if (exp_val !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      word_count++;
      if (expected_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected word, expected none actual status %0d element %h",
                 $time, rsp_ch.status, rsp_ch.element);
      end else begin
        want = expected_q.pop_front();
        check_field("status", want.status, rsp_ch.status);
        check_field("found_index", want.found_index, rsp_ch.found_index);
        check_field("element", want.element, rsp_ch.element);
        check_field("element_index", want.element_index, rsp_ch.element_index);
        check_field("last", want.last, rsp_ch.last);
        check_field("count", want.count, rsp_ch.count);
        check_field("min_value", want.min_value, rsp_ch.min_value);
        check_field("max_value", want.max_value, rsp_ch.max_value);
      end
    end
  end

  // receiver stall pattern, with a long hold when asked
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ch.ready <= 1'b0;
    end else if (hold_off) begin
      hold_off = 1'b0;
      hold_left = HOLD_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 2);
        rx_left = $urandom_range(16, 128);
      end
      rx_left--;
      case (rx_style)
        0:       rsp_ch.ready <= 1'b1;
        1:       rsp_ch.ready <= ($urandom_range(0, 3) != 0);
        default: rsp_ch.ready <= ($urandom_range(0, 2) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // tests
  task automatic test_empty_list();
    send_request(MODE_DEL_FRONT, '0, '0);
    send_request(MODE_DEL_BACK, '0, '0);
    send_request(MODE_DEL_AT, '0, 5'd0);
    send_request(MODE_SEARCH, '0, '0);
    send_request(MODE_READ_ALL, '0, '0);
  endtask

  task automatic test_edge_values();
    send_request(MODE_INS_BACK, 32'sh8000_0000, '0);
    send_request(MODE_INS_FRONT, 32'sh7fff_ffff, '0);
    send_request(MODE_INS_AT, -32'sd1, 5'd1);
    send_request(MODE_INS_AT, 32'sd5, 5'd5);
    send_request(MODE_INS_AT, 32'sd0, 5'd3);
    send_request(MODE_INS_AT, 32'sd7, 5'd2);
    send_request(MODE_INS_AT, 32'sd7, 5'd0);
    send_request(MODE_SEARCH, 32'sd7, '0);
    send_request(MODE_SEARCH, 32'sh8000_0000, '0);
    send_request(MODE_SEARCH, 32'sd12345, '0);
    send_request(MODE_READ_ALL, '0, '0);
    send_request(MODE_DEL_AT, '0, 5'd6);
    send_request(MODE_DEL_AT, '0, 5'd31);
    send_request(MODE_INS_AT, 32'sd9, 5'd16);
    send_request(MODE_DEL_AT, '0, 5'd1);
    send_request(MODE_DEL_BACK, '0, '0);
    send_request(MODE_DEL_FRONT, '0, '0);
    send_request(MODE_READ_ALL, '0, '0);
  endtask

  task automatic test_full_list();
    while (shadow_count < LIST_DEPTH) send_request(MODE_INS_BACK, rand_value(), '0);
    send_request(MODE_INS_FRONT, rand_value(), '0);
    send_request(MODE_INS_BACK, rand_value(), '0);
    send_request(MODE_INS_AT, rand_value(), 5'd16);
    send_request(MODE_READ_ALL, '0, '0);
    send_request(MODE_SEARCH, shadow_list[LIST_DEPTH - 1], '0);
    send_request(MODE_DEL_AT, '0, 5'd16);
    send_request(MODE_DEL_AT, '0, 5'd15);
    while (shadow_count > 0) send_random(0);
    send_request(MODE_READ_ALL, '0, '0);
  endtask

  task automatic test_output_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 6; i++) send_request(MODE_INS_BACK, rand_value(), '0);
    send_request(MODE_READ_ALL, '0, '0);
    send_request(MODE_SEARCH, rand_value(), '0);
    send_request(MODE_READ_ALL, '0, '0);
    send_request(MODE_DEL_FRONT, '0, '0);
  endtask

  task automatic test_random_mix();
    for (int phase = 0; phase < 4; phase++) begin
      for (int i = 0; i < 85; i++) send_random((phase % 2 == 0) ? 65 : 30);
    end
  endtask

  initial begin
    error_count = 0;
    sent_count  = 0;
    word_count  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    hold_off    = 1'b0;
    hold_left   = 0;
    rx_left     = 0;
    rx_style    = 0;
    shadow_count = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_list();
    test_edge_values();
    test_full_list();
    test_output_backpressure();
    test_random_mix();

    req_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d requests and %0d result words: empty, full, bad index,",
             sent_count, word_count);
    $display("search hits and misses, read all, extreme values and a long output stall");
    if (error_count == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
